// ----- design/tosv_pkg.sv -----
// shared types, codes, constants and sine table builder for the three oscillator voice
package tosv_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int PHASE_BITS_DEF = 24;
    localparam int SINE_DEPTH_DEF = 1024;
    localparam int SINE_W         = 16;
    localparam int INC_W          = 24;
    localparam int GAIN_W         = 16;
    localparam int WSEL_W         = 6;
    localparam int CFG_DATA_W     = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int OUT_SHIFT      = 32 - SAMPLE_BITS;

    localparam logic [WSEL_W-1:0] WSEL_RESET = 6'd21;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1365;
    localparam logic [GAIN_W-1:0] MGAIN_RESET = 16'hFFFF;

    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        FUNC_NOTE_START   = 2'd0,
        FUNC_TICK         = 2'd1,
        FUNC_RELEASE      = 2'd2,
        FUNC_FAST_RELEASE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_SQUARE = 2'd2
    } t_wave;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_SELECT = 3'd0,
        CFG_INCREMENT_A = 3'd1,
        CFG_INCREMENT_B = 3'd2,
        CFG_INCREMENT_C = 3'd3,
        CFG_GAIN_A      = 3'd4,
        CFG_GAIN_B      = 3'd5,
        CFG_GAIN_C      = 3'd6,
        CFG_MASTER_GAIN = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_func       func;
        logic [15:0] peak_level;
        logic [15:0] fast_step;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          note_done;
        logic                          voice_active;
    } t_out_item;

    // sine table entry k of a 2^addr_w deep table, Q1.15
    function automatic logic signed [SINE_W-1:0] f_sine_entry(input int unsigned k,
                                                               input int unsigned addr_w);
        longint unsigned f;
        longint unsigned r;
        longint unsigned u;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        longint unsigned q;
        f = 64'(k) << (32 - addr_w);
        q = (f >> 30) & 64'd3;
        r = f & (Q30 - 64'd1);
        u = q[0] ? Q30 - r : r;
        x = (u * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t = Q30;
        t = Q30 - ((x2 * t) >> 30) / 110;
        t = Q30 - ((x2 * t) >> 30) / 72;
        t = Q30 - ((x2 * t) >> 30) / 42;
        t = Q30 - ((x2 * t) >> 30) / 20;
        t = Q30 - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        v = (s * 64'd32767 + (Q30 >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return (q >= 64'd2) ? -SINE_W'(v) : SINE_W'(v);
    endfunction

endpackage

// ----- design/three_osc_synth_voice_core.sv -----
// three oscillator synth voice: mixer, fifth power shaper and envelope on one shared multiplier
//
// A sample tick on a sounding voice runs these steps before the next item is accepted:
// three table reads and mix products, a rounding step, five shaping and gain products of
// two 24 bit limb passes each through the single 24 x 28 multiplier, and an output step.
// Note start, release, fast release and ticks on an idle voice are handled without leaving the idle state.
// Results sit in an output register; the input is held off while that register is stalled.
// The sine table is a constant ROM of SINE_TABLE_DEPTH entries with a registered read.
module three_osc_synth_voice_core
    import tosv_pkg::*;
#(
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MIX, S_MAG, S_MUL_LO, S_MUL_HI, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MODE_IDLE, MODE_SOUNDING, MODE_RELEASED, MODE_FAST
    } t_mode;

    typedef enum logic [2:0] {
        OP_M2, OP_M4, OP_M5, OP_T, OP_Y
    } t_op;

    t_state r_state;
    t_mode  r_mode;
    t_op    r_op;

    logic [WSEL_W-1:0]     r_wave_sel;
    logic [INC_W-1:0]      r_inc_a, r_inc_b, r_inc_c;
    logic [GAIN_W-1:0]     r_gain_a, r_gain_b, r_gain_c, r_master_gain;
    logic [PHASE_BITS-1:0] r_phase_a, r_phase_b, r_phase_c;
    logic [15:0]           r_amp, r_decay;
    logic                  r_done;
    logic                  r_neg;
    logic [1:0]            r_osc;
    logic signed [34:0]    r_sum;
    logic [20:0]           r_m;
    logic [47:0]           r_x;
    logic [63:0]           r_acc;
    logic                  r_out_valid;
    t_out_item             r_out_data;
    logic signed [SINE_W-1:0] r_rom_q;

    logic signed [SINE_W-1:0] w_sine_rom [SINE_TABLE_DEPTH];

    logic                  w_in_fire;
    logic                  w_idle_tick;
    logic [PHASE_BITS-1:0] w_osc_phase;
    logic [1:0]            w_osc_sel;
    logic [GAIN_W-1:0]     w_osc_gain;
    logic [ADDR_W-1:0]     w_rom_addr;
    logic [15:0]           w_wave_mag;
    logic                  w_wave_neg;
    logic [23:0]           w_mul_a;
    logic [27:0]           w_mul_b;
    logic [51:0]           w_mul_p;
    logic [4:0]            w_shift;
    logic [63:0]           w_round;
    logic signed [34:0]    w_prod_s;
    logic [33:0]           w_abs;
    logic [47:0]           w_lim;
    logic [47:0]           w_y_sat;
    logic [15:0]           n_amp;
    logic signed [34:0]    n_sum;
    logic [63:0]           n_acc_lo;
    logic [63:0]           n_acc_hi;
    logic [47:0]           n_x;
    logic [20:0]           n_m;
    logic [SAMPLE_BITS-1:0] n_sample;

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
        assign w_sine_rom[g] = f_sine_entry(g, ADDR_W);
    end

    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign w_idle_tick = w_in_fire && (i_in_data.func == FUNC_TICK) && (r_mode == MODE_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // oscillator select
    always_comb begin
        unique case (r_osc)
            2'd0: begin
                w_osc_phase = r_phase_a;
                w_osc_sel   = r_wave_sel[1:0];
                w_osc_gain  = r_gain_a;
            end
            2'd1: begin
                w_osc_phase = r_phase_b;
                w_osc_sel   = r_wave_sel[3:2];
                w_osc_gain  = r_gain_b;
            end
            default: begin
                w_osc_phase = r_phase_c;
                w_osc_sel   = r_wave_sel[5:4];
                w_osc_gain  = r_gain_c;
            end
        endcase
    end

    assign w_rom_addr = w_osc_phase[PHASE_BITS-1 -: ADDR_W];

    always_ff @(posedge i_clk) begin
        r_rom_q <= w_sine_rom[w_rom_addr];
    end

    // waveform as sign and magnitude
    always_comb begin
        case (w_osc_sel)
            WAVE_SINE: begin
                w_wave_neg = r_rom_q[SINE_W-1];
                w_wave_mag = w_wave_neg ? 16'(-r_rom_q) : 16'(r_rom_q);
            end
            WAVE_SAW: begin
                w_wave_neg = 1'b0;
                w_wave_mag = {1'b0, w_osc_phase[PHASE_BITS-1 -: 15]};
            end
            WAVE_SQUARE: begin
                w_wave_neg = r_rom_q[SINE_W-1];
                w_wave_mag = 16'h8000;
            end
            default: begin
                w_wave_neg = 1'b0;
                w_wave_mag = 16'd0;
            end
        endcase
    end

    // shared multiplier operands
    always_comb begin
        case (r_op)
            OP_M2:   w_mul_b = 28'(r_m);
            OP_M4:   w_mul_b = r_x[27:0];
            OP_M5:   w_mul_b = 28'(r_m);
            OP_T:    w_mul_b = 28'(r_amp);
            OP_Y:    w_mul_b = 28'(r_master_gain);
            default: w_mul_b = 28'd0;
        endcase
        case (r_op)
            OP_T:    w_shift = 5'd16;
            OP_Y:    w_shift = 5'(OUT_SHIFT);
            default: w_shift = 5'd15;
        endcase
        priority case (r_state)
            S_MIX:    w_mul_a = 24'(w_wave_mag);
            S_MUL_LO: w_mul_a = r_x[23:0];
            S_MUL_HI: w_mul_a = r_x[47:24];
            default:  w_mul_a = 24'd0;
        endcase
        if (r_state == S_MIX) begin
            w_mul_b = 28'(w_osc_gain);
        end
    end

    assign w_mul_p  = 52'(w_mul_a) * 52'(w_mul_b);
    assign w_round  = 64'd1 << (w_shift - 5'd1);
    assign n_acc_lo = 64'(w_mul_p) + w_round;
    assign n_acc_hi = r_acc + 64'({w_mul_p, 24'd0});
    assign n_x      = 48'(n_acc_hi >> w_shift);

    assign w_prod_s = $signed({3'd0, w_mul_p[31:0]});
    assign n_sum    = w_wave_neg ? r_sum - w_prod_s : r_sum + w_prod_s;

    assign w_abs = r_sum[34] ? 34'(-r_sum) : 34'(r_sum);
    assign n_m   = 21'((w_abs + 34'd2048) >> 12);

    assign n_amp = (r_amp > r_decay) ? r_amp - r_decay : 16'd0;

    // saturation and sign
    assign w_lim = 48'd1 << (SAMPLE_BITS - 1);
    always_comb begin
        w_y_sat = r_x;
        if (!r_neg && (r_x > w_lim - 48'd1)) begin
            w_y_sat = w_lim - 48'd1;
        end
        if (r_neg && (r_x > w_lim)) begin
            w_y_sat = w_lim;
        end
        n_sample = r_neg ? SAMPLE_BITS'(48'd0 - w_y_sat) : SAMPLE_BITS'(w_y_sat);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_sel    <= WSEL_RESET;
            r_inc_a       <= '0;
            r_inc_b       <= '0;
            r_inc_c       <= '0;
            r_gain_a      <= GAIN_RESET;
            r_gain_b      <= GAIN_RESET;
            r_gain_c      <= GAIN_RESET;
            r_master_gain <= MGAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WAVE_SELECT: r_wave_sel    <= i_cfg_data[WSEL_W-1:0];
                CFG_INCREMENT_A: r_inc_a       <= i_cfg_data[INC_W-1:0];
                CFG_INCREMENT_B: r_inc_b       <= i_cfg_data[INC_W-1:0];
                CFG_INCREMENT_C: r_inc_c       <= i_cfg_data[INC_W-1:0];
                CFG_GAIN_A:      r_gain_a      <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_B:      r_gain_b      <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_C:      r_gain_c      <= i_cfg_data[GAIN_W-1:0];
                CFG_MASTER_GAIN: r_master_gain <= i_cfg_data[GAIN_W-1:0];
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_IDLE;
            r_op        <= OP_M2;
            r_osc       <= 2'd0;
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
            r_phase_a   <= '0;
            r_phase_b   <= '0;
            r_phase_c   <= '0;
            r_amp       <= '0;
            r_decay     <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && !w_idle_tick) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        unique case (i_in_data.func)
                            FUNC_NOTE_START: begin
                                r_phase_a <= '0;
                                r_phase_b <= '0;
                                r_phase_c <= '0;
                                r_amp     <= i_in_data.peak_level;
                                r_decay   <= i_in_data.fast_step;
                                r_mode    <= MODE_SOUNDING;
                            end
                            FUNC_RELEASE: begin
                                if (r_mode == MODE_SOUNDING) begin
                                    r_mode <= MODE_RELEASED;
                                end
                            end
                            FUNC_FAST_RELEASE: begin
                                if (r_mode == MODE_SOUNDING || r_mode == MODE_RELEASED) begin
                                    r_mode <= MODE_FAST;
                                end
                            end
                            FUNC_TICK: begin
                                if (r_mode == MODE_IDLE) begin
                                    r_out_valid <= 1'b1;
                                    r_out_data  <= '0;
                                end else begin
                                    r_done <= (r_mode == MODE_RELEASED) ||
                                              (r_mode == MODE_FAST && r_amp == 16'd0);
                                    if (r_mode == MODE_FAST && r_amp != 16'd0) begin
                                        r_amp <= n_amp;
                                    end
                                    r_osc   <= 2'd0;
                                    r_sum   <= '0;
                                    r_state <= S_READ;
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_sum <= n_sum;
                    if (r_osc == 2'd2) begin
                        r_state <= S_MAG;
                    end else begin
                        r_osc   <= 2'(r_osc + 2'd1);
                        r_state <= S_READ;
                    end
                end
                S_MAG: begin
                    r_neg   <= r_sum[34];
                    r_m     <= n_m;
                    r_x     <= 48'(n_m);
                    r_op    <= OP_M2;
                    r_state <= S_MUL_LO;
                end
                S_MUL_LO: begin
                    r_acc   <= n_acc_lo;
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_x <= n_x;
                    if (r_op == OP_Y) begin
                        r_state <= S_OUT;
                    end else begin
                        r_op    <= t_op'(r_op + 3'd1);
                        r_state <= S_MUL_LO;
                    end
                end
                S_OUT: begin
                    r_out_valid             <= 1'b1;
                    r_out_data.sample       <= n_sample;
                    r_out_data.note_done    <= r_done;
                    r_out_data.voice_active <= 1'b1;
                    r_phase_a <= r_phase_a + PHASE_BITS'(r_inc_a);
                    r_phase_b <= r_phase_b + PHASE_BITS'(r_inc_b);
                    r_phase_c <= r_phase_c + PHASE_BITS'(r_inc_c);
                    if (r_done) begin
                        r_mode <= MODE_IDLE;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("output register holds a result while a tick is in progress");

    a_done_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.note_done) |-> o_out_data.voice_active)
        else $error("note end reported on an inactive voice");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.voice_active) |-> (o_out_data.sample == '0))
        else $error("inactive voice produced a nonzero sample");

endmodule
